// ===== src/cost_aware_request_dispatcher_unit_defines.svh =====
// assertion macros used by the checker file card_chk.sv
`ifndef COST_AWARE_REQUEST_DISPATCHER_UNIT_DEFINES_SVH
`define COST_AWARE_REQUEST_DISPATCHER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CARD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("card check failed");

// next-cycle implication, sampled on clk, off during reset
`define CARD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("card check failed");

`endif

// ===== src/card_pkg.sv =====
package card_pkg;

    localparam int NUM_SERVERS = 4;
    localparam int COST_ROWS   = 4;
    localparam int IDX_W       = $clog2(NUM_SERVERS);
    localparam int CNT_W       = $clog2(NUM_SERVERS + 1);

    localparam int SRV_W    = 2;
    localparam int STATUS_W = 2;
    localparam int LOAD_W   = 8;
    localparam int SIU_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [LOAD_W-1:0] NO_LINK     = 8'hFF;
    localparam logic [SIU_W-1:0]  SIU_RESET   = 3'd4;
    localparam logic [LOAD_W-1:0] LIMIT_RESET = 8'd16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SERVERS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_ROW_0     = 3'd2;

    // commands
    localparam logic CMD_DISPATCH = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    // microcode
    typedef logic [2:0] step_t;

    localparam step_t S_IDLE   = 3'd0;
    localparam step_t S_BRANCH = 3'd1;
    localparam step_t S_SCAN   = 3'd2;
    localparam step_t S_DISP   = 3'd3;
    localparam step_t S_COMPL  = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SCAN,
        OP_DISP,
        OP_COMPL
    } op_t;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } wait_t;

    typedef enum logic [1:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_CMD,
        JMP_SCAN
    } jmp_t;

    typedef struct packed {
        op_t   op;
        wait_t wt;
        jmp_t  jc;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t cw;
        case (step)
            S_IDLE:   cw = '{op: OP_ACCEPT, wt: WAIT_IN,   jc: JMP_NEVER,  target: S_IDLE};
            S_BRANCH: cw = '{op: OP_NOP,    wt: WAIT_NONE, jc: JMP_CMD,    target: S_COMPL};
            S_SCAN:   cw = '{op: OP_SCAN,   wt: WAIT_NONE, jc: JMP_SCAN,   target: S_SCAN};
            S_DISP:   cw = '{op: OP_DISP,   wt: WAIT_OUT,  jc: JMP_ALWAYS, target: S_IDLE};
            S_COMPL:  cw = '{op: OP_COMPL,  wt: WAIT_OUT,  jc: JMP_ALWAYS, target: S_IDLE};
            default:  cw = '{op: OP_NOP,    wt: WAIT_NONE, jc: JMP_ALWAYS, target: S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

// ===== src/card_if.sv =====
interface card_req_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [card_pkg::SRV_W-1:0] server;

    modport source (output valid, output command, output server, input ready);
    modport sink (input valid, input command, input server, output ready);
endinterface

interface card_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [card_pkg::SRV_W-1:0]    chosen_server;
    logic [card_pkg::STATUS_W-1:0] status;
    logic [card_pkg::LOAD_W-1:0]   new_load;

    modport source (output valid, output chosen_server, output status, output new_load,
                    input ready);
    modport sink (input valid, input chosen_server, input status, input new_load,
                  output ready);
endinterface

// ===== src/cost_aware_request_dispatcher_unit.sv =====
// cost-aware request dispatcher
// req channel (valid/ready): one word per command, command 0 dispatches a
// request from the named source server, command 1 completes a request on
// the named server. rsp channel (valid/ready): one word per command with
// chosen_server, status and new_load.
// configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// to be written by the user only while no command is in flight; not enforced.
// timing: a small microcode table steps the datapath. a dispatch runs
// accept, branch, one compare step per active server plus one exit step
// (only the exit step for a source outside the active range), dispatch;
// a completion runs accept, branch, complete.
// one command is in flight at a time; req ready is high only in the idle
// step, so a new command is taken only after the last one has put its
// result in the output register.
// the result sits in an output register; the next command is accepted
// while it waits, and the sequencer only stalls when a new result is due
// and the old one is still not taken.
// reset: all server loads clear, servers_in_use = 4, load_limit = 16,
// all link costs 255 (no link); no clearing pass is needed.
module cost_aware_request_dispatcher_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    card_req_if.sink                          req,
    card_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [card_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [card_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // configuration
    logic [card_pkg::SIU_W-1:0]      siu_reg;
    logic [card_pkg::LOAD_W-1:0]     limit_reg;
    logic [card_pkg::CFG_DATA_W-1:0] cost_reg [card_pkg::COST_ROWS];

    // sequencer
    card_pkg::step_t step_reg, step_next;
    card_pkg::ctrl_t cw;

    // datapath
    logic                         cmd_reg, cmd_next;
    logic [card_pkg::SRV_W-1:0]   srv_reg, srv_next;
    logic [card_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic                         have_reg, have_next;
    logic [card_pkg::IDX_W-1:0]   pick_reg, pick_next;
    logic [card_pkg::LOAD_W-1:0]  pick_load_reg, pick_load_next;
    logic [card_pkg::LOAD_W-1:0]  best_reg, best_next;
    logic [card_pkg::LOAD_W-1:0]  load_reg [card_pkg::NUM_SERVERS];

    logic                            rsp_valid_reg, rsp_valid_next;
    logic [card_pkg::SRV_W-1:0]      chosen_reg, chosen_next;
    logic [card_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [card_pkg::LOAD_W-1:0]     new_load_reg, new_load_next;

    logic [card_pkg::CNT_W-1:0]      active;
    logic [card_pkg::IDX_W-1:0]      rd_addr;
    logic [card_pkg::LOAD_W-1:0]     rd_load;
    logic [card_pkg::CFG_DATA_W-1:0] row;
    logic [card_pkg::LOAD_W-1:0]     cost_i;
    logic                            src_ok;
    logic                            scan_cont;
    logic                            take;
    logic                            slot_free;
    logic                            hold;
    logic                            jump;
    logic                            wr_en;
    logic [card_pkg::IDX_W-1:0]      wr_addr;
    logic [card_pkg::LOAD_W-1:0]     wr_data;

    assign cw = card_pkg::ucode(step_reg);

    assign active = (int'(siu_reg) > card_pkg::NUM_SERVERS)
                  ? card_pkg::CNT_W'(card_pkg::NUM_SERVERS)
                  : card_pkg::CNT_W'(siu_reg);

    assign src_ok    = card_pkg::CNT_W'(srv_reg) < active;
    assign scan_cont = src_ok && (idx_reg < active);

    assign rd_addr = (cw.op == card_pkg::OP_SCAN) ? idx_reg[card_pkg::IDX_W-1:0]
                                                  : card_pkg::IDX_W'(srv_reg);
    assign rd_load = load_reg[rd_addr];

    assign row    = cost_reg[srv_reg];
    assign cost_i = (int'(idx_reg) < card_pkg::COST_ROWS)
                  ? row[{idx_reg[1:0], 3'b000} +: 8] : card_pkg::NO_LINK;

    assign take = scan_cont
               && (idx_reg != card_pkg::CNT_W'(srv_reg))
               && (cost_i != card_pkg::NO_LINK)
               && (rd_load < limit_reg)
               && (!have_reg || (rd_load < pick_load_reg))
               && (cost_i < best_reg);

    assign slot_free = !rsp_valid_reg || rsp.ready;

    assign req.ready = (cw.wt == card_pkg::WAIT_IN);

    always_comb
    begin
        case (cw.wt)
            card_pkg::WAIT_IN:  hold = !req.valid;
            card_pkg::WAIT_OUT: hold = !slot_free;
            default:            hold = 1'b0;
        endcase
        case (cw.jc)
            card_pkg::JMP_ALWAYS: jump = 1'b1;
            card_pkg::JMP_CMD:    jump = (cmd_reg == card_pkg::CMD_COMPLETE);
            card_pkg::JMP_SCAN:   jump = scan_cont;
            default:              jump = 1'b0;
        endcase
        if (hold)
            step_next = step_reg;
        else if (jump)
            step_next = cw.target;
        else
            step_next = step_reg + 3'd1;
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        srv_next       = srv_reg;
        idx_next       = idx_reg;
        have_next      = have_reg;
        pick_next      = pick_reg;
        pick_load_next = pick_load_reg;
        best_next      = best_reg;
        chosen_next    = chosen_reg;
        status_next    = status_reg;
        new_load_next  = new_load_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        wr_en          = 1'b0;
        wr_addr        = card_pkg::IDX_W'(srv_reg);
        wr_data        = rd_load - 8'd1;
        case (cw.op)
            card_pkg::OP_ACCEPT:
            begin
                if (req.valid)
                begin
                    cmd_next  = req.command;
                    srv_next  = req.server;
                    idx_next  = '0;
                    have_next = 1'b0;
                    best_next = card_pkg::NO_LINK;
                end
            end
            card_pkg::OP_SCAN:
            begin
                if (scan_cont)
                    idx_next = idx_reg + 1'b1;
                if (take)
                begin
                    have_next      = 1'b1;
                    best_next      = cost_i;
                    pick_next      = idx_reg[card_pkg::IDX_W-1:0];
                    pick_load_next = rd_load;
                end
            end
            card_pkg::OP_DISP:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (have_reg)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = pick_reg;
                        wr_data       = pick_load_reg + 8'd1;
                        chosen_next   = card_pkg::SRV_W'(pick_reg);
                        status_next   = card_pkg::ST_OK;
                        new_load_next = pick_load_reg + 8'd1;
                    end
                    else
                    begin
                        chosen_next   = '0;
                        status_next   = card_pkg::ST_NONE;
                        new_load_next = '0;
                    end
                end
            end
            card_pkg::OP_COMPL:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (src_ok && (rd_load != '0))
                    begin
                        wr_en         = 1'b1;
                        chosen_next   = srv_reg;
                        status_next   = card_pkg::ST_OK;
                        new_load_next = rd_load - 8'd1;
                    end
                    else
                    begin
                        chosen_next   = '0;
                        status_next   = card_pkg::ST_BAD;
                        new_load_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siu_reg   <= card_pkg::SIU_RESET;
            limit_reg <= card_pkg::LIMIT_RESET;
            for (int r = 0; r < card_pkg::COST_ROWS; r++)
                cost_reg[r] <= '1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == card_pkg::CFG_SERVERS_IN_USE)
                siu_reg <= cfg_data[card_pkg::SIU_W-1:0];
            else if (cfg_index == card_pkg::CFG_LOAD_LIMIT)
                limit_reg <= cfg_data[card_pkg::LOAD_W-1:0];
            else
            begin
                for (int r = 0; r < card_pkg::COST_ROWS; r++)
                begin
                    if (int'(cfg_index) == int'(card_pkg::CFG_COST_ROW_0) + r)
                        cost_reg[r] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= card_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int s = 0; s < card_pkg::NUM_SERVERS; s++)
                load_reg[s] <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
            if (wr_en)
                load_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        srv_reg       <= srv_next;
        idx_reg       <= idx_next;
        have_reg      <= have_next;
        pick_reg      <= pick_next;
        pick_load_reg <= pick_load_next;
        best_reg      <= best_next;
        chosen_reg    <= chosen_next;
        status_reg    <= status_next;
        new_load_reg  <= new_load_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.chosen_server = chosen_reg;
    assign rsp.status        = status_reg;
    assign rsp.new_load      = new_load_reg;

endmodule

// ===== src/card_chk.sv =====
`include "cost_aware_request_dispatcher_unit_defines.svh"

module card_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [card_pkg::SRV_W-1:0]      rsp_chosen_server,
    input logic [card_pkg::STATUS_W-1:0]   rsp_status,
    input logic [card_pkg::LOAD_W-1:0]     rsp_new_load
);

    // a stalled result word holds
    `CARD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_chosen_server) && $stable(rsp_status) && $stable(rsp_new_load))

    // failures report server 0 and load 0
    `CARD_ASSERT_NOW(a_fail_zero, rsp_valid && (rsp_status != card_pkg::ST_OK), (rsp_chosen_server == '0) && (rsp_new_load == '0))

    // one command in flight: no accept right after an accept
    `CARD_ASSERT_NEXT(a_one_inflight, req_valid && req_ready, !req_ready)

    // status never carries the unused code
    `CARD_ASSERT_NOW(a_status_code, rsp_valid, (rsp_status == card_pkg::ST_OK) || (rsp_status == card_pkg::ST_NONE) || (rsp_status == card_pkg::ST_BAD))

endmodule

bind cost_aware_request_dispatcher_unit card_chk u_card_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_chosen_server (rsp.chosen_server),
    .rsp_status        (rsp.status),
    .rsp_new_load      (rsp.new_load)
);

// ===== test/cost_aware_request_dispatcher_unit_test.sv =====
`timescale 1ns / 100ps

module cost_aware_request_dispatcher_unit_test;
    import card_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_WORDS     = 78;

    typedef struct packed {
        logic             command;
        logic [SRV_W-1:0] server;
    } cmd_word_t;

    typedef struct packed {
        logic [SRV_W-1:0]    chosen_server;
        logic [STATUS_W-1:0] status;
        logic [LOAD_W-1:0]   new_load;
    } rsp_word_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    card_req_if req_bus ();
    card_rsp_if rsp_bus ();

    cost_aware_request_dispatcher_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block's registers and load counters
    logic [SIU_W-1:0]      cur_servers = SIU_RESET;
    logic [LOAD_W-1:0]     cur_limit   = LIMIT_RESET;
    logic [CFG_DATA_W-1:0] cur_cost [COST_ROWS] = '{default: '1};
    logic [LOAD_W-1:0]     predicted_load [NUM_SERVERS] = '{default: '0};

    cmd_word_t pending_commands [$];
    rsp_word_t expected_results [$];

    int mismatches = 0;
    int placed_dispatches = 0;
    int refused_dispatches = 0;
    int done_completions = 0;
    int rejected_completions = 0;
    int settings_applied = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_off_asks = 0;
    int hold_off_served = 0;
    int hold_left = 0;
    int stall_left = 0;
    int stall_pct = 0;
    int style_cycles = 0;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rsp_word_t apply_command(input cmd_word_t w);
        rsp_word_t   r;
        int unsigned active;
        int unsigned pick;
        int unsigned best;
        int unsigned link;
        bit          have;
        r = '{chosen_server: '0, status: ST_OK, new_load: '0};
        active = (cur_servers > NUM_SERVERS) ? NUM_SERVERS : cur_servers;
        if (w.command == CMD_DISPATCH)
        begin
            have = 1'b0;
            pick = 0;
            best = NO_LINK;
            if (w.server < active)
            begin
                for (int unsigned i = 0; i < active; i++)
                begin
                    link = (i < COST_ROWS) ? ((cur_cost[w.server] >> (8 * i)) & 8'hFF) : NO_LINK;
                    if (i != w.server && link != NO_LINK && predicted_load[i] < cur_limit)
                    begin
                        if ((!have || predicted_load[i] < predicted_load[pick]) && link < best)
                        begin
                            best = link;
                            pick = i;
                            have = 1'b1;
                        end
                    end
                end
            end
            if (have)
            begin
                predicted_load[pick] = predicted_load[pick] + 1'b1;
                r.chosen_server = SRV_W'(pick);
                r.new_load = predicted_load[pick];
                placed_dispatches++;
            end
            else
            begin
                r.status = ST_NONE;
                refused_dispatches++;
            end
        end
        else
        begin
            if (w.server < active && predicted_load[w.server] != 0)
            begin
                predicted_load[w.server] = predicted_load[w.server] - 1'b1;
                r.chosen_server = w.server;
                r.new_load = predicted_load[w.server];
                done_completions++;
            end
            else
            begin
                r.status = ST_BAD;
                rejected_completions++;
            end
        end
        return r;
    endfunction

    // driver: bursts of words with random gaps, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin : drive_commands
        if (!rst_n)
        begin
            req_bus.valid   <= 1'b0;
            req_bus.command <= CMD_DISPATCH;
            req_bus.server  <= '0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                expected_results.push_back(apply_command(pending_commands.pop_front()));
            if (!(req_bus.valid && !req_bus.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end
                else if (pending_commands.size() != 0)
                begin
                    req_bus.valid   <= 1'b1;
                    req_bus.command <= pending_commands[0].command;
                    req_bus.server  <= pending_commands[0].server;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result word and drives the receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin : collect_results
        rsp_word_t got;
        rsp_word_t want;
        logic      next_ready;
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got = '{rsp_bus.chosen_server, rsp_bus.status, rsp_bus.new_load};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with nothing outstanding: server %0d status %0d load %0d",
                                 $time, got.chosen_server, got.status, got.new_load);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.chosen_server !== want.chosen_server || got.status !== want.status ||
                        got.new_load !== want.new_load)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected server %0d status %0d load %0d, got server %0d status %0d load %0d",
                                     $time, want.chosen_server, want.status, want.new_load,
                                     got.chosen_server, got.status, got.new_load);
                    end
                end
            end
            if (style_cycles == 0)
            begin
                style_cycles = 128;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 60;
                endcase
            end
            style_cycles--;
            if (hold_off_served != hold_off_asks)
            begin
                hold_off_served = hold_off_asks;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 7);
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
            rsp_bus.ready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && (pending_commands.size() != 0 || expected_results.size() != 0))
        begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
        else
            quiet_cycles = 0;
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SERVERS_IN_USE)
            cur_servers = data[SIU_W-1:0];
        else if (idx == CFG_LOAD_LIMIT)
            cur_limit = data[LOAD_W-1:0];
        else if (idx >= CFG_COST_ROW_0 && idx < CFG_COST_ROW_0 + CFG_IDX_W'(COST_ROWS))
            cur_cost[idx - CFG_COST_ROW_0] = data;
    endtask

    task automatic queue_command(input logic command, input logic [SRV_W-1:0] server);
        pending_commands.push_back('{command: command, server: server});
    endtask

    task automatic queue_random_commands(input int count);
        repeat (count)
            queue_command(($urandom_range(0, 99) < 55) ? CMD_DISPATCH : CMD_COMPLETE,
                          SRV_W'($urandom_range(0, NUM_SERVERS - 1)));
    endtask

    // wait until every word is answered, then let the sequencer go idle
    task automatic settle();
        while (pending_commands.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_cost_row();
        logic [CFG_DATA_W-1:0] row;
        int                    pick;
        for (int b = 0; b < 4; b++)
        begin
            pick = $urandom_range(0, 7);
            if (pick < 2)
                row[8*b +: 8] = NO_LINK;
            else if (pick == 2)
                row[8*b +: 8] = 8'h00;
            else if (pick == 3)
                row[8*b +: 8] = 8'hFE;
            else
                row[8*b +: 8] = 8'($urandom_range(0, 255));
        end
        return row;
    endfunction

    task automatic apply_setting(input int p);
        logic [SIU_W-1:0]      siu;
        logic [LOAD_W-1:0]     lim;
        logic [CFG_DATA_W-1:0] row;
        case (p)
            0: begin siu = 3'd1; lim = 8'd0;   end
            1: begin siu = 3'd4; lim = 8'd1;   end
            2: begin siu = 3'd2; lim = 8'd3;   end
            3: begin siu = 3'd3; lim = 8'($urandom_range(1, 6)); end
            RANDOM_PHASES - 1: begin siu = 3'd4; lim = 8'd255; end
            default:
            begin
                siu = SIU_W'($urandom_range(1, NUM_SERVERS));
                lim = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(1, 6));
            end
        endcase
        write_register(CFG_SERVERS_IN_USE, {29'($urandom()), siu});
        write_register(CFG_LOAD_LIMIT, {24'($urandom()), lim});
        for (int r = 0; r < COST_ROWS; r++)
        begin
            if (p == 4)
                row = '0;
            else if (p == 6)
                row = '1;
            else
                row = random_cost_row();
            write_register(CFG_COST_ROW_0 + CFG_IDX_W'(r), row);
        end
        // indexes past the cost rows must be ignored
        if (p == 5)
        begin
            write_register(CFG_COST_ROW_0 + CFG_IDX_W'(COST_ROWS), $urandom());
            write_register(CFG_COST_ROW_0 + CFG_IDX_W'(COST_ROWS + 1), $urandom());
        end
        settings_applied++;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_bus.valid = 1'b0;
        req_bus.command = CMD_DISPATCH;
        req_bus.server = '0;
        rsp_bus.ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: no links, so every dispatch is refused
        for (int s = 0; s < NUM_SERVERS; s++)
            queue_command(CMD_DISPATCH, SRV_W'(s));
        queue_command(CMD_COMPLETE, 2'd0);
        queue_command(CMD_COMPLETE, 2'd3);
        settle();

        write_register(CFG_SERVERS_IN_USE, 32'd4);
        write_register(CFG_LOAD_LIMIT, 32'd2);
        write_register(CFG_COST_ROW_0, 32'h00FE10FF);
        write_register(CFG_COST_ROW_0 + 3'd1, 32'h050505FF);
        write_register(CFG_COST_ROW_0 + 3'd2, 32'hFFFF0102);
        write_register(CFG_COST_ROW_0 + 3'd3, 32'hFF804020);
        settings_applied++;
        @(negedge clk);
        queue_command(CMD_COMPLETE, 2'd2);
        repeat (3) queue_command(CMD_DISPATCH, 2'd0);
        repeat (2) queue_command(CMD_DISPATCH, 2'd1);
        repeat (2) queue_command(CMD_DISPATCH, 2'd2);
        repeat (3) queue_command(CMD_DISPATCH, 2'd3);
        queue_command(CMD_COMPLETE, 2'd3);
        queue_command(CMD_COMPLETE, 2'd0);
        queue_command(CMD_COMPLETE, 2'd1);
        repeat (2) queue_command(CMD_COMPLETE, 2'd2);
        repeat (2) queue_command(CMD_DISPATCH, 2'd0);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            apply_setting(p);
            queue_random_commands(PHASE_WORDS);
            // receiver backs off for a long stretch while the sender keeps offering
            if (p == 2)
                hold_off_asks++;
            settle();
        end

        $display("ran %0d command words over %0d register settings", placed_dispatches +
                 refused_dispatches + done_completions + rejected_completions, settings_applied);
        $display("dispatches placed %0d refused %0d, completions done %0d rejected %0d",
                 placed_dispatches, refused_dispatches, done_completions, rejected_completions);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
